### hw/rtl/pcsmm_pkg.sv
// pcsmm_pkg: shared constants, opcodes and table record types for the
// per-cell / per-species running min, max and mean block.
// No dependencies.
`timescale 1ns / 1ps

package pcsmm_pkg;

  // Payload widths fixed by the interface
  localparam int CONC_W       = 32;
  localparam int CELL_SUM_W   = 48;
  localparam int SPEC_SUM_W   = 54;
  localparam int OPCODE_W     = 2;
  localparam int CELL_IDX_W   = 6;
  localparam int SPEC_IDX_W   = 4;
  localparam int CELL_CNT_W   = 7;
  localparam int SPEC_CNT_W   = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  // Parameter defaults
  localparam int MAX_CELLS_DEF   = 64;
  localparam int MAX_SPECIES_DEF = 16;
  localparam int STEP_BITS_DEF   = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_STEP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIES_COUNT = 1'd1;

  localparam logic [CELL_CNT_W-1:0] CELL_COUNT_RST    = 7'd64;
  localparam logic [SPEC_CNT_W-1:0] SPECIES_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [CONC_W-1:0]     min;
    logic [CONC_W-1:0]     max;
    logic [CELL_SUM_W-1:0] sum;
  } cell_rec_t;

  typedef struct packed {
    logic [CONC_W-1:0]     min;
    logic [CONC_W-1:0]     max;
    logic [SPEC_SUM_W-1:0] sum;
  } spec_rec_t;

  localparam cell_rec_t CELL_REC_RST = '{min: '1, max: '0, sum: '0};
  localparam spec_rec_t SPEC_REC_RST = '{min: '1, max: '0, sum: '0};

endpackage

### hw/rtl/per_cell_species_min_max_mean_unit.sv
// Running min / max / mean statistics per (cell, species) entry and per
// species; tables in on-chip memories, means through pcsmm_div.
// Depends on pcsmm_pkg and pcsmm_div.
// A sample holds busy through a fetch state and a write-back state; an
// end of step or ignored transaction does not raise busy. A read result
// comes from the bit-serial divider used twice. Results cannot stall.
// Reset: a clearing pass over all MAX_CELLS*MAX_SPECIES entries (1024 by
// default) holds busy high; config writes are taken during it.
`timescale 1ns / 1ps

module per_cell_species_min_max_mean_unit #(
  parameter int MAX_CELLS   = pcsmm_pkg::MAX_CELLS_DEF,
  parameter int MAX_SPECIES = pcsmm_pkg::MAX_SPECIES_DEF,
  parameter int STEP_BITS   = pcsmm_pkg::STEP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pcsmm_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [pcsmm_pkg::CELL_IDX_W-1:0]  in_cell_index,
  input  logic [pcsmm_pkg::SPEC_IDX_W-1:0]  in_species_index,
  input  logic [pcsmm_pkg::CONC_W-1:0]      in_concentration,
  output logic                              out_valid,
  output logic [pcsmm_pkg::CONC_W-1:0]      out_cell_minimum,
  output logic [pcsmm_pkg::CONC_W-1:0]      out_cell_maximum,
  output logic [pcsmm_pkg::CONC_W-1:0]      out_cell_mean,
  output logic [pcsmm_pkg::CONC_W-1:0]      out_species_minimum,
  output logic [pcsmm_pkg::CONC_W-1:0]      out_species_maximum,
  output logic [pcsmm_pkg::CONC_W-1:0]      out_species_mean,
  output logic                              out_no_steps,
  input  logic                              cfg_we,
  input  logic [pcsmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcsmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ENTRIES = MAX_CELLS * MAX_SPECIES;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW      = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
  localparam int CNW     = pcsmm_pkg::CELL_CNT_W;
  localparam int DVW     = STEP_BITS + CNW;
  localparam int CW      = pcsmm_pkg::CONC_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_WRITE, ST_CDIV, ST_SDIV
  } state_t;

  state_t state_r;

  logic [CNW-1:0]                    cell_count_r;
  logic [pcsmm_pkg::SPEC_CNT_W-1:0]  species_count_r;
  logic [STEP_BITS-1:0]              step_r;
  logic [AW-1:0]                     clr_cnt_r;

  // latched transaction
  logic [pcsmm_pkg::OPCODE_W-1:0]    op_r;
  logic                              cell_ok_r;
  logic                              spec_ok_r;
  logic [AW-1:0]                     addr_r;
  logic [SW-1:0]                     saddr_r;
  logic [CW-1:0]                     conc_r;
  logic [DVW-1:0]                    prod_r;
  logic [CW-1:0]                     cmean_r;

  // tables
  pcsmm_pkg::cell_rec_t cell_mem [ENTRIES];
  pcsmm_pkg::spec_rec_t spec_mem [MAX_SPECIES];
  pcsmm_pkg::cell_rec_t cell_q_r;
  pcsmm_pkg::spec_rec_t spec_q_r;

  // result registers
  logic          out_valid_r;
  logic [CW-1:0] cmin_out_r, cmax_out_r, cmean_out_r;
  logic [CW-1:0] smin_out_r, smax_out_r, smean_out_r;
  logic          no_steps_r;

  logic accept;
  logic spec_ok, cell_ok;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_saddr;
  logic [CNW-1:0] cells_eff;
  logic steps_zero;

  // write port
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SW-1:0]        wr_saddr;
  pcsmm_pkg::cell_rec_t cell_wr;
  pcsmm_pkg::spec_rec_t spec_wr;

  // merge
  logic [pcsmm_pkg::CELL_SUM_W:0] csum;
  logic [pcsmm_pkg::SPEC_SUM_W:0] ssum;
  pcsmm_pkg::cell_rec_t cell_upd;
  pcsmm_pkg::spec_rec_t spec_upd;

  // divider
  logic                             div_start;
  logic [pcsmm_pkg::SPEC_SUM_W-1:0] div_dividend;
  logic [DVW-1:0]                   div_divisor;
  logic                             div_done;
  logic [CW-1:0]                    div_q;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign spec_ok = ({1'b0, in_species_index} < species_count_r)
                   && (32'(in_species_index) < MAX_SPECIES);
  assign cell_ok = spec_ok && (CNW'(in_cell_index) < cell_count_r)
                   && (32'(in_cell_index) < MAX_CELLS);
  assign rd_addr  = AW'(32'(in_cell_index) * MAX_SPECIES + 32'(in_species_index));
  assign rd_saddr = SW'(in_species_index);

  always_comb begin
    if (cell_count_r == '0) begin
      cells_eff = CNW'(1);
    end else if (32'(cell_count_r) > MAX_CELLS) begin
      cells_eff = CNW'(MAX_CELLS);
    end else begin
      cells_eff = cell_count_r;
    end
  end

  assign steps_zero = (step_r == '0);

  // sample merge
  assign csum = {1'b0, cell_q_r.sum} + (pcsmm_pkg::CELL_SUM_W + 1)'(conc_r);
  assign ssum = {1'b0, spec_q_r.sum} + (pcsmm_pkg::SPEC_SUM_W + 1)'(conc_r);

  always_comb begin
    cell_upd.min = (conc_r < cell_q_r.min) ? conc_r : cell_q_r.min;
    cell_upd.max = (conc_r > cell_q_r.max) ? conc_r : cell_q_r.max;
    cell_upd.sum = csum[pcsmm_pkg::CELL_SUM_W] ? '1 : csum[pcsmm_pkg::CELL_SUM_W-1:0];
    spec_upd.min = (conc_r < spec_q_r.min) ? conc_r : spec_q_r.min;
    spec_upd.max = (conc_r > spec_q_r.max) ? conc_r : spec_q_r.max;
    spec_upd.sum = ssum[pcsmm_pkg::SPEC_SUM_W] ? '1 : ssum[pcsmm_pkg::SPEC_SUM_W-1:0];
  end

  // clearing pass and write-back share one write port; the species
  // address wraps during clearing, which only rewrites reset values
  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = clr_cnt_r;
      wr_saddr = clr_cnt_r[SW-1:0];
      cell_wr  = pcsmm_pkg::CELL_REC_RST;
      spec_wr  = pcsmm_pkg::SPEC_REC_RST;
    end else begin
      wr_en    = (state_r == ST_WRITE);
      wr_addr  = addr_r;
      wr_saddr = saddr_r;
      cell_wr  = cell_upd;
      spec_wr  = spec_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr]  <= cell_wr;
      spec_mem[wr_saddr] <= spec_wr;
    end
    if (accept) begin
      cell_q_r <= cell_mem[rd_addr];
      spec_q_r <= spec_mem[rd_saddr];
    end
  end

  // divider feed: cell mean first, then species mean
  always_comb begin
    div_start    = 1'b0;
    div_dividend = pcsmm_pkg::SPEC_SUM_W'(cell_q_r.sum);
    div_divisor  = DVW'(step_r);
    case (state_r)
      ST_FETCH: begin
        div_start = (op_r == pcsmm_pkg::OP_READ);
      end
      ST_CDIV: begin
        div_start    = div_done;
        div_dividend = spec_q_r.sum;
        div_divisor  = prod_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pcsmm_div #(.DVW(DVW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .div_done  (div_done),
    .quotient  (div_q)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r    <= pcsmm_pkg::CELL_COUNT_RST;
      species_count_r <= pcsmm_pkg::SPECIES_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcsmm_pkg::REG_CELL_COUNT:    cell_count_r    <= cfg_data;
        pcsmm_pkg::REG_SPECIES_COUNT: species_count_r <= pcsmm_pkg::SPEC_CNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(ENTRIES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r      <= in_opcode;
            cell_ok_r <= cell_ok;
            spec_ok_r <= spec_ok;
            addr_r    <= rd_addr;
            saddr_r   <= rd_saddr;
            conc_r    <= in_concentration;
            case (in_opcode)
              pcsmm_pkg::OP_SAMPLE: begin
                if (cell_ok) begin
                  state_r <= ST_FETCH;
                end
              end
              pcsmm_pkg::OP_STEP: begin
                if (step_r != '1) begin
                  step_r <= step_r + 1'b1;
                end
              end
              pcsmm_pkg::OP_READ: begin
                state_r <= ST_FETCH;
              end
              default: ;
            endcase
          end
        end
        ST_FETCH: begin
          prod_r <= DVW'(step_r) * DVW'(cells_eff);
          if (op_r == pcsmm_pkg::OP_READ) begin
            state_r <= ST_CDIV;
          end else begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_r <= ST_IDLE;
        end
        ST_CDIV: begin
          if (div_done) begin
            cmean_r <= div_q;
            state_r <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            cmin_out_r  <= cell_ok_r ? cell_q_r.min : '0;
            cmax_out_r  <= cell_ok_r ? cell_q_r.max : '0;
            cmean_out_r <= (cell_ok_r && !steps_zero) ? cmean_r : '0;
            smin_out_r  <= spec_ok_r ? spec_q_r.min : '0;
            smax_out_r  <= spec_ok_r ? spec_q_r.max : '0;
            smean_out_r <= (spec_ok_r && !steps_zero) ? div_q : '0;
            no_steps_r  <= steps_zero;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_minimum    = cmin_out_r;
  assign out_cell_maximum    = cmax_out_r;
  assign out_cell_mean       = cmean_out_r;
  assign out_species_minimum = smin_out_r;
  assign out_species_maximum = smax_out_r;
  assign out_species_mean    = smean_out_r;
  assign out_no_steps        = no_steps_r;

endmodule

### hw/rtl/pcsmm_div.sv
// pcsmm_div: shared restoring divider, one quotient bit per cycle,
// quotient saturated to 32 bits. Depends on pcsmm_pkg.
`timescale 1ns / 1ps

module pcsmm_div #(
  parameter int DVW = pcsmm_pkg::STEP_BITS_DEF + pcsmm_pkg::CELL_CNT_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              div_start,
  input  logic [pcsmm_pkg::SPEC_SUM_W-1:0]  dividend,
  input  logic [DVW-1:0]                    divisor,
  output logic                              div_done,
  output logic [pcsmm_pkg::CONC_W-1:0]      quotient
);

  localparam int DDW = pcsmm_pkg::SPEC_SUM_W;
  localparam int CW  = $clog2(DDW);
  localparam logic [CW-1:0] LAST = CW'(DDW - 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] divisor_r;
  logic [DDW-1:0] dq_r;     // dividend shifts out, quotient shifts in

  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           ge;

  assign trial = {rem_r, dq_r[DDW-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign ge    = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        rem_r     <= '0;
        dq_r      <= dividend;
        divisor_r <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
        dq_r  <= {dq_r[DDW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_done = done_r;
  assign quotient = (|dq_r[DDW-1:pcsmm_pkg::CONC_W]) ? '1 : dq_r[pcsmm_pkg::CONC_W-1:0];

endmodule
